// ===== design/mdfb_pkg.sv =====
// Shared types and constants of the marker-delimited frame buffer.
// No dependencies; used by the controller and the top level.
package mdfb_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 3;

  // Register indexes, taken from paddr[2]
  localparam logic REG_OPEN_MARK  = 1'b0;
  localparam logic REG_CLOSE_MARK = 1'b1;

  localparam logic [ByteW-1:0] OPEN_MARK_RST  = 8'h02;
  localparam logic [ByteW-1:0] CLOSE_MARK_RST = 8'h03;

  typedef struct packed {
    logic [ByteW-1:0] open_mark;
    logic [ByteW-1:0] close_mark;
  } cfg_t;

endpackage

// ===== design/marker_delimited_frame_buffer.sv =====
// Marker-delimited frame buffer (start/end marker deframer). Each received
// byte is one input item: it is compared against the two marker registers
// and, inside a frame, written to the frame store until FRAME_BYTES are held
// (later bytes are dropped and flag the frame as truncated). A closing
// marker, or an opening marker inside a frame, starts a replay of the n
// stored bytes, one result item per byte in arrival order with the last one
// marked, or a single item without a byte for an empty frame. Each result is
// read through the store's registered read port into the output register; a
// new read is issued only after the previous one has reached that register,
// and no byte is accepted until the replay's last read or empty item issues.
// The store needs no clearing after reset. Marker registers sit at APB
// addresses 0 and 4. Depends on mdfb_pkg, mdfb_ctrl and mdfb_store.
module marker_delimited_frame_buffer #(
  parameter int unsigned FRAME_BYTES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mdfb_pkg::AddrW-1:0]  paddr,
  input  logic [mdfb_pkg::DataW-1:0]  pwdata,
  output logic [mdfb_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  frame_byte_o,
  output logic                        has_byte_o,
  output logic                        last_of_frame_o,
  output logic                        truncated_o,
  output logic                        closed_by_start_o
);

  localparam int unsigned AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  mdfb_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic           reg_sel;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_mark  <= mdfb_pkg::OPEN_MARK_RST;
      cfg_q.close_mark <= mdfb_pkg::CLOSE_MARK_RST;
    end else if (wr_en) begin
      case (reg_sel)
        mdfb_pkg::REG_OPEN_MARK:  cfg_q.open_mark  <= pwdata[7:0];
        mdfb_pkg::REG_CLOSE_MARK: cfg_q.close_mark <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mdfb_pkg::REG_OPEN_MARK:  prdata = {24'h0, cfg_q.open_mark};
      mdfb_pkg::REG_CLOSE_MARK: prdata = {24'h0, cfg_q.close_mark};
      default:                  prdata = '0;
    endcase
  end

  mdfb_ctrl #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_byte_o     (frame_byte_o),
    .has_byte_o       (has_byte_o),
    .last_of_frame_o  (last_of_frame_o),
    .truncated_o      (truncated_o),
    .closed_by_start_o(closed_by_start_o)
  );

  mdfb_store #(
    .DEPTH(FRAME_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

// ===== design/mdfb_store.sv =====
// Frame byte store: one write port, one read port, registered read data.
// Depends on nothing; instantiated by marker_delimited_frame_buffer.
module mdfb_store #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [7:0]                            wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [7:0]                            rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mdfb_ctrl.sv =====
// Deframing controller: marker detection, fill of the store, frame replay
// and the output register. Depends on mdfb_pkg; drives mdfb_store.
module mdfb_ctrl #(
  parameter int unsigned FRAME_BYTES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mdfb_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  output logic                mem_we_o,
  output logic [((FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1)-1:0] mem_waddr_o,
  output logic [7:0]          mem_wdata_o,
  output logic                mem_re_o,
  output logic [((FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1)-1:0] mem_raddr_o,
  input  logic [7:0]          mem_rdata_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          frame_byte_o,
  output logic                has_byte_o,
  output logic                last_of_frame_o,
  output logic                truncated_o,
  output logic                closed_by_start_o
);

  localparam int unsigned AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned CW = $clog2(FRAME_BYTES + 1);
  localparam logic [CW-1:0] Limit = CW'(FRAME_BYTES);

  typedef enum logic {
    S_COLLECT,
    S_REPLAY
  } state_e;

  state_e        state_q;
  logic          in_frame_q;
  logic [CW-1:0] fill_q;
  logic          ovf_q;
  logic [CW-1:0] n_q;
  logic [CW-1:0] k_q;
  logic          trunc_q;
  logic          by_start_q;
  logic          pend_q;
  logic          pend_last_q;
  logic          out_valid_q;
  logic [7:0]    frame_byte_q;
  logic          has_byte_q;
  logic          last_q;
  logic          trunc_out_q;
  logic          by_start_out_q;

  logic accept;
  logic is_start;
  logic is_end;
  logic out_free;
  logic can_go;
  logic issue;
  logic issue_last;

  assign accept     = in_valid_i && (state_q == S_COLLECT);
  assign is_start   = (rx_byte_i == cfg_i.open_mark);
  assign is_end     = (rx_byte_i == cfg_i.close_mark);
  // Next read only when the output register is sure to be free on its return
  assign out_free   = !out_valid_q || out_ready_i;
  assign can_go     = (state_q == S_REPLAY) && !pend_q && out_free;
  assign issue      = can_go && (n_q != '0);
  assign issue_last = ((k_q + CW'(1)) == n_q);

  assign in_ready_o  = (state_q == S_COLLECT);
  assign mem_we_o    = accept && in_frame_q && !is_start && !is_end && (fill_q < Limit);
  assign mem_waddr_o = fill_q[AW-1:0];
  assign mem_wdata_o = rx_byte_i;
  assign mem_re_o    = issue;
  assign mem_raddr_o = k_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_COLLECT;
      in_frame_q     <= 1'b0;
      fill_q         <= '0;
      ovf_q          <= 1'b0;
      n_q            <= '0;
      k_q            <= '0;
      trunc_q        <= 1'b0;
      by_start_q     <= 1'b0;
      pend_q         <= 1'b0;
      pend_last_q    <= 1'b0;
      out_valid_q    <= 1'b0;
      frame_byte_q   <= '0;
      has_byte_q     <= 1'b0;
      last_q         <= 1'b0;
      trunc_out_q    <= 1'b0;
      by_start_out_q <= 1'b0;
    end else begin
      // byte side
      if (accept) begin
        if (!in_frame_q) begin
          if (is_start) begin
            in_frame_q <= 1'b1;
            fill_q     <= '0;
            ovf_q      <= 1'b0;
          end
        end else if (is_end || is_start) begin
          // end marker wins when both markers match
          n_q        <= fill_q;
          k_q        <= '0;
          trunc_q    <= ovf_q;
          by_start_q <= !is_end;
          in_frame_q <= !is_end;
          fill_q     <= '0;
          ovf_q      <= 1'b0;
          state_q    <= S_REPLAY;
        end else if (fill_q < Limit) begin
          fill_q <= fill_q + CW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end

      // replay side
      pend_q <= issue;
      if (issue) begin
        pend_last_q <= issue_last;
        k_q         <= k_q + CW'(1);
        if (issue_last) begin
          state_q <= S_COLLECT;
        end
      end

      // output register
      if (can_go && (n_q == '0)) begin
        out_valid_q    <= 1'b1;
        frame_byte_q   <= '0;
        has_byte_q     <= 1'b0;
        last_q         <= 1'b1;
        trunc_out_q    <= trunc_q;
        by_start_out_q <= by_start_q;
        state_q        <= S_COLLECT;
      end else if (pend_q) begin
        out_valid_q    <= 1'b1;
        frame_byte_q   <= mem_rdata_i;
        has_byte_q     <= 1'b1;
        last_q         <= pend_last_q;
        trunc_out_q    <= trunc_q;
        by_start_out_q <= by_start_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_byte_o      = frame_byte_q;
  assign has_byte_o        = has_byte_q;
  assign last_of_frame_o   = last_q;
  assign truncated_o       = trunc_out_q;
  assign closed_by_start_o = by_start_out_q;

endmodule

// ===== design/mdfb_chk.sv =====
// Port-level checker for marker_delimited_frame_buffer, with its bind.
// Depends on no package; its port widths are written out directly.
module mdfb_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       pready,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [7:0]                 frame_byte_o,
  input logic                       has_byte_o,
  input logic                       last_of_frame_o
);

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_byte_o)
      && $stable(last_of_frame_o))
    else $error("stalled result item changed");

  // an empty frame is a single, final item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> last_of_frame_o)
    else $error("empty frame item not marked last");

  // input is not ready while a result item other than the last is valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_frame_o |-> !in_ready_o)
    else $error("input ready during frame replay");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind marker_delimited_frame_buffer mdfb_chk u_mdfb_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .pready         (pready),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .frame_byte_o   (frame_byte_o),
  .has_byte_o     (has_byte_o),
  .last_of_frame_o(last_of_frame_o)
);
